// ===== rtl/core/c8_pkg.sv =====
// Shared types, constants and the font table for the CHIP-8 machine core.
// Depends on nothing; chip8_cpu_core imports it.
package c8_pkg;

   localparam int MEM_BYTES      = 4096;
   localparam int DISPLAY_WIDTH  = 64;
   localparam int DISPLAY_HEIGHT = 32;
   localparam int STACK_DEPTH    = 16;

   localparam logic [11:0] PROGRAM_START = 12'h200;
   localparam logic [11:0] FONT_BASE     = 12'h050;
   localparam int          FONT_BYTES    = 80;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_EXEC  = 2'd1,
      MODE_ROW   = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ROW, S_F1, S_F2, S_RX, S_RY, S_LATCHY, S_EX,
      S_WBF, S_WBX, S_CLS, S_RET, S_DR0, S_DR1, S_DRF,
      S_BCD, S_B2, S_B1, S_B0, S_SR, S_SW, S_LR, S_LW, S_DONE
   } state_type;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // Reset contents of main memory at one address.
   function automatic logic [7:0] boot_byte(input logic [11:0] a);
      logic [11:0] off;
      off = a - FONT_BASE;
      if (a >= FONT_BASE && a < FONT_BASE + 12'(FONT_BYTES))
         return FONT_ROM[off[6:0]];
      return 8'h00;
   endfunction

endpackage

// ===== rtl/core/c8_req_if.sv =====
// Request channel of the CHIP-8 core: valid/ready plus one item.
// Depends on nothing.
interface c8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] address;
   logic [7:0]  data;
   logic [15:0] keys;
   logic [7:0]  random_byte;
   modport source (output valid, mode, address, data, keys, random_byte, input ready);
   modport sink   (input valid, mode, address, data, keys, random_byte, output ready);
endinterface

// ===== rtl/core/c8_rsp_if.sv =====
// Result channel of the CHIP-8 core: valid/ready plus one result.
// Depends on nothing.
interface c8_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_counter;
   logic [15:0] executed_opcode;
   logic [63:0] display_row;
   logic        sound_on;
   logic        waiting_for_key;
   modport source (output valid, program_counter, executed_opcode, display_row,
                   sound_on, waiting_for_key, input ready);
   modport sink   (input valid, program_counter, executed_opcode, display_row,
                   sound_on, waiting_for_key, output ready);
endinterface

// ===== rtl/core/chip8_cpu_core.sv =====
// CHIP-8 machine core: memory load, one-instruction execute, display row read.
// Depends on c8_pkg, c8_req_if and c8_rsp_if.
//
// After reset the core clears main memory (font at 0x050), registers, stack and
// frame store, one address a cycle, with req.ready low. A load or an unused mode
// registers its response at the accepting edge; a row read first reads the frame
// store. An execute goes through a sequencer around one-read, one-write memories:
// opcode fetch, Vx and Vy reads, execute, then a register write (after a VF write
// for flag-setting ALU ops) where needed; screen clear runs one frame row a cycle,
// draw reads and rewrites each sprite row, and BCD store and block store or load
// move one byte per step.
// One transaction is in flight at a time.
module chip8_cpu_core (
   input  logic clock,
   input  logic reset,
   c8_req_if.sink   req,
   c8_rsp_if.source rsp
);
   import c8_pkg::*;

   logic [7:0]  mem   [MEM_BYTES];
   logic [7:0]  vreg  [16];
   logic [11:0] stk   [STACK_DEPTH];
   logic [63:0] frame [DISPLAY_HEIGHT];

   state_type   state_ff, state_in;
   logic [11:0] clr_ff, clr_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] i_ff, i_in;
   logic [3:0]  sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [15:0] op_ff, op_in;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        flag_ff, flag_in;
   logic [7:0]  res_ff, res_in;
   logic [3:0]  h_ff, h_in, t_ff, t_in;
   logic        wait_ff, wait_in;
   logic [15:0] key_ff, key_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [4:0]  row_ff, row_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_pc_ff, rsp_pc_in;
   logic [15:0] rsp_op_ff, rsp_op_in;
   logic [63:0] rsp_row_ff, rsp_row_in;
   logic        rsp_snd_ff, rsp_snd_in;
   logic        rsp_wait_ff, rsp_wait_in;

   logic [7:0]  mem_q_ff, v_q_ff;
   logic [63:0] fr_q_ff;
   logic [11:0] stk_q_ff;

   logic        mem_we, v_we, fr_we, stk_we;
   logic [11:0] mem_waddr, mem_raddr, stk_wdata;
   logic [7:0]  mem_wdata, v_wdata;
   logic [3:0]  v_waddr, v_raddr, stk_waddr, stk_raddr;
   logic [4:0]  fr_waddr, fr_raddr;
   logic [63:0] fr_wdata, sprite_mask;
   logic        take;
   logic [3:0]  x, y, n, key_idx;
   logic [7:0]  kk, alu_res;
   logic        alu_flag, key_any;
   logic [8:0]  sum9;
   logic [5:0]  row_pos;
   logic [15:0] font_addr;

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign take      = req.valid && req.ready;

   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign kk = op_ff[7:0];

   assign row_pos     = {1'b0, vy_ff[4:0]} + {1'b0, cnt_ff};
   assign sprite_mask = {mem_q_ff, 56'd0} >> vx_ff[5:0];
   assign font_addr   = 16'(FONT_BASE) + {8'd0, vx_ff} * 16'd5;
   assign sum9        = {1'b0, vx_ff} + {1'b0, vy_ff};

   // Lowest pressed key.
   always_comb begin
      key_idx = 4'd0;
      key_any = 1'b0;
      for (int k = 15; k >= 0; k--) begin
         if (key_ff[k]) begin
            key_idx = 4'(k);
            key_any = 1'b1;
         end
      end
   end

   // Shared ALU for the register forms.
   always_comb begin
      alu_res  = 8'd0;
      alu_flag = 1'b0;
      unique case (n)
         4'h0: alu_res = vy_ff;
         4'h1: alu_res = vx_ff | vy_ff;
         4'h2: alu_res = vx_ff & vy_ff;
         4'h3: alu_res = vx_ff ^ vy_ff;
         4'h4: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
         4'h5: begin alu_res = vx_ff - vy_ff; alu_flag = vx_ff > vy_ff; end
         4'h6: begin alu_res = {1'b0, vx_ff[7:1]}; alu_flag = vx_ff[0]; end
         4'h7: begin alu_res = vy_ff - vx_ff; alu_flag = vy_ff > vx_ff; end
         4'hE: begin alu_res = {vx_ff[6:0], 1'b0}; alu_flag = vx_ff[7]; end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;   pc_in = pc_ff;   i_in = i_ff;
      sp_in = sp_ff;        dt_in = dt_ff;     st_in = st_ff;   op_in = op_ff;
      vx_in = vx_ff;        vy_in = vy_ff;     cnt_in = cnt_ff; flag_in = flag_ff;
      res_in = res_ff;      h_in = h_ff;       t_in = t_ff;     wait_in = wait_ff;
      key_in = key_ff;      rnd_in = rnd_ff;   row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pc_in = rsp_pc_ff; rsp_op_in = rsp_op_ff; rsp_row_in = rsp_row_ff;
      rsp_snd_in = rsp_snd_ff; rsp_wait_in = rsp_wait_ff;
      mem_we = 1'b0; mem_waddr = 12'd0; mem_wdata = 8'd0; mem_raddr = pc_ff;
      v_we = 1'b0;   v_waddr = 4'd0;    v_wdata = 8'd0;   v_raddr = x;
      fr_we = 1'b0;  fr_waddr = 5'd0;   fr_wdata = 64'd0; fr_raddr = row_ff;
      stk_we = 1'b0; stk_waddr = sp_ff; stk_wdata = pc_ff; stk_raddr = sp_ff - 4'd1;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1; mem_waddr = clr_ff; mem_wdata = boot_byte(clr_ff);
            v_we = 1'b1;   v_waddr = clr_ff[3:0];
            stk_we = 1'b1; stk_waddr = clr_ff[3:0]; stk_wdata = 12'd0;
            fr_we = 1'b1;  fr_waddr = clr_ff[4:0];
            clr_in = clr_ff + 12'd1;
            if (clr_ff == 12'(MEM_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (take) begin
               key_in = req.keys; rnd_in = req.random_byte;
               row_in = req.address[4:0];
               fr_raddr = req.address[4:0];
               wait_in = 1'b0;
               unique case (mode_type'(req.mode))
                  MODE_LOAD, MODE_SPARE: begin
                     if (mode_type'(req.mode) == MODE_LOAD) begin
                        mem_we = 1'b1; mem_waddr = req.address; mem_wdata = req.data;
                     end
                     rsp_valid_in = 1'b1; rsp_pc_in = pc_ff; rsp_op_in = 16'd0;
                     rsp_row_in = 64'd0; rsp_snd_in = st_ff != 8'd0;
                     rsp_wait_in = 1'b0;
                  end
                  MODE_ROW:  state_in = S_ROW;
                  MODE_EXEC: state_in = S_F1;
               endcase
            end
         end
         S_ROW: begin
            rsp_valid_in = 1'b1; rsp_pc_in = pc_ff; rsp_op_in = 16'd0;
            rsp_row_in = fr_q_ff; rsp_snd_in = st_ff != 8'd0; rsp_wait_in = 1'b0;
            state_in = S_IDLE;
         end
         S_F1: begin
            op_in[15:8] = mem_q_ff;
            mem_raddr = pc_ff + 12'd1;
            state_in = S_F2;
         end
         S_F2: begin
            op_in[7:0] = mem_q_ff;
            pc_in = pc_ff + 12'd2;
            state_in = S_RX;
         end
         S_RX: begin
            v_raddr = x;
            state_in = S_RY;
         end
         S_RY: begin
            vx_in = v_q_ff;
            v_raddr = (op_ff[15:12] == 4'hB) ? 4'd0 : y;
            state_in = S_LATCHY;
         end
         S_LATCHY: begin
            vy_in = v_q_ff;
            state_in = S_EX;
         end
         S_EX: begin
            state_in = S_DONE;
            unique case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     cnt_in = 5'd0; state_in = S_CLS;
                  end else if (op_ff == 16'h00EE) begin
                     sp_in = sp_ff - 4'd1; state_in = S_RET;
                  end
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin
                  stk_we = 1'b1; sp_in = sp_ff + 4'd1; pc_in = op_ff[11:0];
               end
               4'h3: if (vx_ff == kk) pc_in = pc_ff + 12'd2;
               4'h4: if (vx_ff != kk) pc_in = pc_ff + 12'd2;
               4'h5: if (vx_ff == vy_ff) pc_in = pc_ff + 12'd2;
               4'h6: begin res_in = kk; state_in = S_WBX; end
               4'h7: begin res_in = vx_ff + kk; state_in = S_WBX; end
               4'h8: begin
                  res_in = alu_res; flag_in = alu_flag;
                  priority case (n)
                     4'h0, 4'h1, 4'h2, 4'h3: state_in = S_WBX;
                     4'h4, 4'h5, 4'h6, 4'h7, 4'hE: state_in = S_WBF;
                     default: state_in = S_DONE;
                  endcase
               end
               4'h9: if (vx_ff != vy_ff) pc_in = pc_ff + 12'd2;
               4'hA: i_in = {4'd0, op_ff[11:0]};
               4'hB: pc_in = {4'd0, vy_ff} + op_ff[11:0];
               4'hC: begin res_in = rnd_ff & kk; state_in = S_WBX; end
               4'hD: begin flag_in = 1'b0; cnt_in = 5'd0; state_in = S_DR0; end
               4'hE: begin
                  if ((kk == 8'h9E && key_ff[vx_ff[3:0]]) ||
                      (kk == 8'hA1 && !key_ff[vx_ff[3:0]]))
                     pc_in = pc_ff + 12'd2;
               end
               4'hF: begin
                  priority case (kk)
                     8'h07: begin res_in = dt_ff; state_in = S_WBX; end
                     8'h0A: begin
                        if (key_any) begin
                           res_in = {4'd0, key_idx}; state_in = S_WBX;
                        end else begin
                           pc_in = pc_ff - 12'd2; wait_in = 1'b1;
                        end
                     end
                     8'h15: dt_in = vx_ff;
                     8'h18: st_in = vx_ff;
                     8'h1E: i_in = i_ff + {8'd0, vx_ff};
                     8'h29: i_in = font_addr;
                     8'h33: begin
                        res_in = vx_ff; h_in = 4'd0; t_in = 4'd0; state_in = S_BCD;
                     end
                     8'h55: begin cnt_in = 5'd0; state_in = S_SR; end
                     8'h65: begin cnt_in = 5'd0; state_in = S_LR; end
                     default: state_in = S_DONE;
                  endcase
               end
            endcase
         end
         S_WBF: begin
            v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, flag_ff};
            state_in = S_WBX;
         end
         S_WBX: begin
            v_we = 1'b1; v_waddr = x; v_wdata = res_ff;
            state_in = S_DONE;
         end
         S_CLS: begin
            fr_we = 1'b1; fr_waddr = cnt_ff;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DISPLAY_HEIGHT - 1)) state_in = S_DONE;
         end
         S_RET: begin
            pc_in = stk_q_ff;
            state_in = S_DONE;
         end
         S_DR0: begin
            // Stop at sprite height or the bottom edge.
            if ({1'b0, cnt_ff} >= {2'd0, n} || row_pos >= 6'(DISPLAY_HEIGHT)) begin
               state_in = S_DRF;
            end else begin
               mem_raddr = 12'(i_ff + {11'd0, cnt_ff});
               fr_raddr  = row_pos[4:0];
               state_in  = S_DR1;
            end
         end
         S_DR1: begin
            fr_we = 1'b1; fr_waddr = row_pos[4:0];
            fr_wdata = fr_q_ff ^ sprite_mask;
            if ((fr_q_ff & sprite_mask) != 64'd0) flag_in = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            state_in = S_DR0;
         end
         S_DRF: begin
            v_we = 1'b1; v_waddr = 4'hF; v_wdata = {7'd0, flag_ff};
            state_in = S_DONE;
         end
         S_BCD: begin
            // Peel hundreds, then tens, by repeated subtraction.
            if (res_ff >= 8'd100) begin
               res_in = res_ff - 8'd100; h_in = h_ff + 4'd1;
            end else if (res_ff >= 8'd10) begin
               res_in = res_ff - 8'd10; t_in = t_ff + 4'd1;
            end else begin
               state_in = S_B2;
            end
         end
         S_B2: begin
            mem_we = 1'b1; mem_waddr = 12'(i_ff + 16'd2); mem_wdata = res_ff;
            state_in = S_B1;
         end
         S_B1: begin
            mem_we = 1'b1; mem_waddr = 12'(i_ff + 16'd1); mem_wdata = {4'd0, t_ff};
            state_in = S_B0;
         end
         S_B0: begin
            mem_we = 1'b1; mem_waddr = i_ff[11:0]; mem_wdata = {4'd0, h_ff};
            state_in = S_DONE;
         end
         S_SR: begin
            v_raddr = cnt_ff[3:0];
            state_in = S_SW;
         end
         S_SW: begin
            mem_we = 1'b1; mem_waddr = 12'(i_ff + {11'd0, cnt_ff}); mem_wdata = v_q_ff;
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff[3:0] == x) ? S_DONE : S_SR;
         end
         S_LR: begin
            mem_raddr = 12'(i_ff + {11'd0, cnt_ff});
            state_in = S_LW;
         end
         S_LW: begin
            v_we = 1'b1; v_waddr = cnt_ff[3:0]; v_wdata = mem_q_ff;
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff[3:0] == x) ? S_DONE : S_LR;
         end
         S_DONE: begin
            if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
            if (st_ff != 8'd0) st_in = st_ff - 8'd1;
            rsp_valid_in = 1'b1; rsp_pc_in = pc_ff; rsp_op_in = op_ff;
            rsp_row_in = 64'd0; rsp_snd_in = st_ff > 8'd1; rsp_wait_in = wait_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= 12'd0; pc_ff <= PROGRAM_START;
         i_ff <= 16'd0; sp_ff <= 4'd0; dt_ff <= 8'd0; st_ff <= 8'd0;
         rsp_valid_ff <= 1'b0; wait_ff <= 1'b0; cnt_ff <= 5'd0; flag_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; pc_ff <= pc_in;
         i_ff <= i_in; sp_ff <= sp_in; dt_ff <= dt_in; st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in; wait_ff <= wait_in; cnt_ff <= cnt_in;
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; vx_ff <= vx_in; vy_ff <= vy_in; res_ff <= res_in;
      h_ff <= h_in; t_ff <= t_in; key_ff <= key_in; rnd_ff <= rnd_in;
      row_ff <= row_in;
      rsp_pc_ff <= rsp_pc_in; rsp_op_ff <= rsp_op_in; rsp_row_ff <= rsp_row_in;
      rsp_snd_ff <= rsp_snd_in; rsp_wait_ff <= rsp_wait_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) vreg[v_waddr] <= v_wdata;
      v_q_ff <= vreg[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (fr_we) frame[fr_waddr] <= fr_wdata;
      fr_q_ff <= frame[fr_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk[stk_waddr] <= stk_wdata;
      stk_q_ff <= stk[stk_raddr];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.program_counter = rsp_pc_ff;
   assign rsp.executed_opcode = rsp_op_ff;
   assign rsp.display_row     = rsp_row_ff;
   assign rsp.sound_on        = rsp_snd_ff;
   assign rsp.waiting_for_key = rsp_wait_ff;

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready)
      else $error("request taken during clearing pass");

   a_done_responds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff)
      else $error("execute finished without a response");

   a_draw_in_height: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DR1 |-> cnt_ff < {1'b0, n})
      else $error("sprite row beyond height");

   a_wait_only_fx0a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wait_ff |-> rsp_op_ff[15:12] == 4'hF && rsp_op_ff[7:0] == 8'h0A)
      else $error("key wait flagged for another opcode");

endmodule
